FILE: hw/rtl/fhv_pkg.sv
package fhv_pkg;

    // Header geometry
    localparam int SIG_BYTES = 4;
    localparam int PSEC_LEN  = SIG_BYTES + 5;
    localparam int DSEC_LEN  = SIG_BYTES + 12;
    localparam int HDR_LEN   = PSEC_LEN + DSEC_LEN;
    localparam int CNT_W     = $clog2(HDR_LEN + 1);

    // Byte positions in the header, at counter width
    localparam logic [CNT_W-1:0] POS_TYPE     = CNT_W'(SIG_BYTES);
    localparam logic [CNT_W-1:0] POS_PCRC_END = CNT_W'(PSEC_LEN - 1);
    localparam logic [CNT_W-1:0] POS_PSEC_END = CNT_W'(PSEC_LEN);
    localparam logic [CNT_W-1:0] POS_DSIG_END = CNT_W'(PSEC_LEN + SIG_BYTES);
    localparam logic [CNT_W-1:0] POS_PSZ_END  = CNT_W'(PSEC_LEN + SIG_BYTES + 4);
    localparam logic [CNT_W-1:0] POS_BSZ_END  = CNT_W'(PSEC_LEN + SIG_BYTES + 8);
    localparam logic [CNT_W-1:0] POS_HDR_END  = CNT_W'(HDR_LEN);

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY   = 32'hEDB8_8320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFF_FFFF;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROTO_SIG = 1'd0,
        CFG_DATA_SIG  = 1'd1
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [2:0] {
        STATUS_OK        = 3'd0,
        STATUS_TRUNCATED = 3'd1,
        STATUS_BAD_CRC   = 3'd2,
        STATUS_UNKNOWN   = 3'd3,
        STATUS_TOO_LONG  = 3'd4
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  msg_type;
        logic [31:0] pld_len;
        logic [31:0] blk_len;
    } fhv_result_t;

    // One byte through the reflected CRC-32
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: hw/rtl/fhv_hdr_core.sv
module fhv_hdr_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                byte_fire,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    input  logic [63:0]         proto_sig,
    input  logic [63:0]         data_sig,
    output fhv_pkg::fhv_result_t result
);
    import fhv_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      crc_reg, crc_next;
    logic [31:0]      rx_crc_reg, rx_crc_next;
    logic             pcrc_ok_reg, pcrc_ok_next;
    logic             psig_ok_reg, psig_ok_next;
    logic             dsig_ok_reg, dsig_ok_next;
    logic [7:0]       type_reg, type_next;
    logic [31:0]      psz_reg, psz_next;
    logic [31:0]      bsz_reg, bsz_next;
    logic             overlong_reg, overlong_next;

    logic [CNT_W-1:0] dsec_off;
    logic [2:0]       psig_idx;
    logic [2:0]       dsig_idx;
    logic [1:0]       psz_idx;
    logic [1:0]       bsz_idx;
    logic [31:0]      crc_upd;
    status_t          status;

    assign dsec_off = cnt_reg - POS_PSEC_END;
    assign psig_idx = cnt_reg[2:0];
    assign dsig_idx = dsec_off[2:0];
    assign psz_idx  = 2'(dsec_off - CNT_W'(SIG_BYTES));
    assign bsz_idx  = 2'(dsec_off - CNT_W'(SIG_BYTES + 4));
    assign crc_upd  = crc32_byte(crc_reg, data_byte);

    // Per-byte header field decode
    always_comb begin
        cnt_next      = cnt_reg;
        crc_next      = crc_reg;
        rx_crc_next   = rx_crc_reg;
        pcrc_ok_next  = pcrc_ok_reg;
        psig_ok_next  = psig_ok_reg;
        dsig_ok_next  = dsig_ok_reg;
        type_next     = type_reg;
        psz_next      = psz_reg;
        bsz_next      = bsz_reg;
        overlong_next = overlong_reg;
        if (byte_fire) begin
            if (cnt_reg >= POS_HDR_END) begin
                overlong_next = 1'b1;
            end else begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg < POS_TYPE) begin
                    if (proto_sig[{psig_idx, 3'b000} +: 8] != data_byte) begin
                        psig_ok_next = 1'b0;
                    end
                    crc_next = crc_upd;
                end else if (cnt_reg == POS_TYPE) begin
                    type_next = data_byte;
                    crc_next  = crc_upd;
                end else if (cnt_reg < POS_PSEC_END) begin
                    rx_crc_next = {rx_crc_reg[23:0], data_byte};
                    if (cnt_reg == POS_PCRC_END) begin
                        pcrc_ok_next = ((crc_reg ^ CRC_PRESET) == rx_crc_next);
                        crc_next     = CRC_PRESET;
                        rx_crc_next  = '0;
                    end
                end else if (cnt_reg < POS_DSIG_END) begin
                    if (data_sig[{dsig_idx, 3'b000} +: 8] != data_byte) begin
                        dsig_ok_next = 1'b0;
                    end
                    crc_next = crc_upd;
                end else if (cnt_reg < POS_PSZ_END) begin
                    psz_next[{psz_idx, 3'b000} +: 8] = data_byte;
                    crc_next = crc_upd;
                end else if (cnt_reg < POS_BSZ_END) begin
                    bsz_next[{bsz_idx, 3'b000} +: 8] = data_byte;
                    crc_next = crc_upd;
                end else begin
                    rx_crc_next = {rx_crc_reg[23:0], data_byte};
                end
            end
        end
    end

    // Status in priority order, from the post-byte state
    always_comb begin
        if (!overlong_next && (cnt_next < POS_HDR_END)) begin
            status = STATUS_TRUNCATED;
        end else if (overlong_next) begin
            status = STATUS_TOO_LONG;
        end else if (!pcrc_ok_next) begin
            status = STATUS_BAD_CRC;
        end else if (!psig_ok_next) begin
            status = STATUS_UNKNOWN;
        end else if ((crc_next ^ CRC_PRESET) != rx_crc_next) begin
            status = STATUS_BAD_CRC;
        end else if (!dsig_ok_next) begin
            status = STATUS_UNKNOWN;
        end else begin
            status = STATUS_OK;
        end
        result.status   = status;
        result.msg_type = (status == STATUS_OK) ? type_next : 8'd0;
        result.pld_len  = (status == STATUS_OK) ? psz_next : 32'd0;
        result.blk_len  = (status == STATUS_OK) ? bsz_next : 32'd0;
    end

    // Header state; cleared on reset and after every last byte
    always_ff @(posedge aclk) begin
        if (!aresetn || (byte_fire && last_byte)) begin
            cnt_reg      <= '0;
            crc_reg      <= CRC_PRESET;
            rx_crc_reg   <= '0;
            pcrc_ok_reg  <= 1'b0;
            psig_ok_reg  <= 1'b1;
            dsig_ok_reg  <= 1'b1;
            type_reg     <= '0;
            psz_reg      <= '0;
            bsz_reg      <= '0;
            overlong_reg <= 1'b0;
        end else begin
            cnt_reg      <= cnt_next;
            crc_reg      <= crc_next;
            rx_crc_reg   <= rx_crc_next;
            pcrc_ok_reg  <= pcrc_ok_next;
            psig_ok_reg  <= psig_ok_next;
            dsig_ok_reg  <= dsig_ok_next;
            type_reg     <= type_next;
            psz_reg      <= psz_next;
            bsz_reg      <= bsz_next;
            overlong_reg <= overlong_next;
        end
    end

endmodule

FILE: hw/rtl/framed_header_validator_top.sv
// Channel   Dir  Handshake             Payload
// s_        in   s_valid / s_ready     s_data_byte[7:0], s_last_byte
// m_        out  m_valid / m_ready     m_status[2:0], m_msg_type[7:0],
//                                      m_pld_len[31:0], m_blk_len[31:0]
// cfg_      in   cfg_valid / cfg_ready cfg_index, cfg_data[63:0]
//
// One header byte per cycle while s_ready is high; the CRC update and field decode are
// combinational between the byte handshake and the result register.
// The result appears on m_ in the cycle after the transaction carrying the last byte.
// s_ready is low only while a result waits in the output register and m_ready is low.
// aresetn is synchronous, active low; it clears header state and both signatures.
// cfg_ready is always high; no clearing pass after reset.
module framed_header_validator_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [7:0]                    s_data_byte,
    input  logic                          s_last_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [2:0]                    m_status,
    output logic [7:0]                    m_msg_type,
    output logic [31:0]                   m_pld_len,
    output logic [31:0]                   m_blk_len,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fhv_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]                   cfg_data
);
    import fhv_pkg::*;

    logic        s_fire;
    logic [63:0] proto_sig_reg;
    logic [63:0] data_sig_reg;
    logic        m_valid_reg;
    fhv_result_t res;
    fhv_result_t res_reg;

    assign s_ready   = !m_valid_reg || m_ready;
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    // Signature registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            proto_sig_reg <= '0;
            data_sig_reg  <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_PROTO_SIG: proto_sig_reg <= cfg_data;
                CFG_DATA_SIG:  data_sig_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    fhv_hdr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .byte_fire (s_fire),
        .data_byte (s_data_byte),
        .last_byte (s_last_byte),
        .proto_sig (proto_sig_reg),
        .data_sig  (data_sig_reg),
        .result    (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_fire && s_last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && s_last_byte) begin
            res_reg <= res;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = res_reg.status;
    assign m_msg_type = res_reg.msg_type;
    assign m_pld_len  = res_reg.pld_len;
    assign m_blk_len  = res_reg.blk_len;

endmodule

FILE: hw/rtl/fhv_checker.sv
module fhv_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_last_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_msg_type,
    input logic [31:0] m_pld_len,
    input logic [31:0] m_blk_len
);
    import fhv_pkg::*;

    // A stalled result holds
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_msg_type)
            && $stable(m_pld_len) && $stable(m_blk_len))
        else $error("result changed while stalled");

    // A failed header reports zero fields
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |->
            (m_msg_type == 8'd0) && (m_pld_len == 32'd0) && (m_blk_len == 32'd0))
        else $error("fields nonzero on failed status");

    // Last byte transaction gives a result next cycle
    a_last_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_last_byte |=> m_valid)
        else $error("no result after last byte");

    // Other bytes give no result when the output was free
    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !s_last_byte && (!m_valid || m_ready) |=> !m_valid)
        else $error("result without last byte");

    // Reset empties the output
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind framed_header_validator_top fhv_checker u_fhv_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fhv_pkg::*;

    // Header layout as seen by the header tracker
    localparam int SIG_N    = SIG_BYTES;
    localparam int PSEC_N   = SIG_N + 5;
    localparam int DSIG_END = PSEC_N + SIG_N;
    localparam int PSZ_END  = DSIG_END + 4;
    localparam int BSZ_END  = PSZ_END + 4;
    localparam int HDR_N    = HDR_LEN;

    localparam int HOLD_CYCLES = 300;
    localparam int WATCHDOG_NS = 10_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } hdr_item_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [7:0]           s_data_byte = 8'h00;
    logic                 s_last_byte = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [7:0]           m_msg_type;
    logic [31:0]          m_pld_len;
    logic [31:0]          m_blk_len;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [63:0]          cfg_data = '0;

    framed_header_validator_top i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data_byte (s_data_byte),
        .s_last_byte (s_last_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_msg_type  (m_msg_type),
        .m_pld_len   (m_pld_len),
        .m_blk_len   (m_blk_len),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #10 aclk = ~aclk;

    // Stimulus side
    hdr_item_t   tx_bytes[$];
    hdr_item_t   next_item;
    logic [7:0]  hdr_buf[$];
    logic [63:0] gen_proto = '0;
    logic [63:0] gen_data = '0;
    int          tx_idle_pct = 0;
    int          rx_idle_pct = 0;
    bit          tx_pause = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_cnt = 0;
    bit          s_taken = 1'b0;

    // Header tracker state, mirrors what the block should hold
    logic [63:0]  proto_sig_cfg = '0;
    logic [63:0]  data_sig_cfg = '0;
    int           hb_count = 0;
    logic [31:0]  hb_crc = CRC_PRESET;
    logic [31:0]  hb_rx_crc = '0;
    logic [7:0]   hb_type = '0;
    logic [31:0]  hb_psz = '0;
    logic [31:0]  hb_bsz = '0;
    bit           hb_crc1_ok = 1'b0;
    bit           hb_sig1_ok = 1'b1;
    bit           hb_sig2_ok = 1'b1;
    bit           hb_overrun = 1'b0;
    fhv_result_t  header_verdicts[$];

    // Bookkeeping
    int fail_count = 0;
    int bytes_seen = 0;
    int results_checked = 0;
    int status_seen[5] = '{default: 0};

    // Bitwise reflected CRC-32, one input bit per step
    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c = {1'b0, c[31:1]} ^ (fb ? CRC_POLY : 32'h0);
        end
        return c;
    endfunction

    // Track one accepted header byte; a last byte yields a verdict
    task automatic predict_header_byte(input logic [7:0] b, input logic last);
        int          n;
        fhv_result_t v;
        n = hb_count;
        if (n >= HDR_N) begin
            hb_overrun = 1'b1;
        end else begin
            if (n < SIG_N) begin
                if (b != proto_sig_cfg[8*n +: 8]) hb_sig1_ok = 1'b0;
                hb_crc = crc_update(hb_crc, b);
            end else if (n == SIG_N) begin
                hb_type = b;
                hb_crc = crc_update(hb_crc, b);
            end else if (n < PSEC_N) begin
                hb_rx_crc = {hb_rx_crc[23:0], b};
                // first section closes: compare and restart the CRC
                if (n == PSEC_N - 1) begin
                    hb_crc1_ok = (~hb_crc == hb_rx_crc);
                    hb_crc = CRC_PRESET;
                    hb_rx_crc = '0;
                end
            end else if (n < DSIG_END) begin
                if (b != data_sig_cfg[8*(n-PSEC_N) +: 8]) hb_sig2_ok = 1'b0;
                hb_crc = crc_update(hb_crc, b);
            end else if (n < PSZ_END) begin
                hb_psz[8*(n-DSIG_END) +: 8] = b;
                hb_crc = crc_update(hb_crc, b);
            end else if (n < BSZ_END) begin
                hb_bsz[8*(n-PSZ_END) +: 8] = b;
                hb_crc = crc_update(hb_crc, b);
            end else begin
                hb_rx_crc = {hb_rx_crc[23:0], b};
            end
            hb_count = n + 1;
        end

        if (last) begin
            v = '0;
            if (!hb_overrun && hb_count < HDR_N) v.status = STATUS_TRUNCATED;
            else if (hb_overrun)                 v.status = STATUS_TOO_LONG;
            else if (!hb_crc1_ok)                v.status = STATUS_BAD_CRC;
            else if (!hb_sig1_ok)                v.status = STATUS_UNKNOWN;
            else if (~hb_crc != hb_rx_crc)       v.status = STATUS_BAD_CRC;
            else if (!hb_sig2_ok)                v.status = STATUS_UNKNOWN;
            else begin
                v.status = STATUS_OK;
                v.msg_type = hb_type;
                v.pld_len = hb_psz;
                v.blk_len = hb_bsz;
            end
            header_verdicts.push_back(v);
            // every attempt starts from a clean header
            hb_count = 0;
            hb_crc = CRC_PRESET;
            hb_rx_crc = '0;
            hb_crc1_ok = 1'b0;
            hb_sig1_ok = 1'b1;
            hb_sig2_ok = 1'b1;
            hb_type = '0;
            hb_psz = '0;
            hb_bsz = '0;
            hb_overrun = 1'b0;
        end
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Monitor: sample handshakes at the rising edge
    always @(posedge aclk) begin
        fhv_result_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (header_verdicts.size() == 0) begin
                    $display("%0t: result with no header pending, status %0d", $time, m_status);
                    fail_count++;
                end else begin
                    want = header_verdicts.pop_front();
                    check_field("status", 32'(m_status), 32'(want.status));
                    check_field("msg_type", 32'(m_msg_type), 32'(want.msg_type));
                    check_field("pld_len", m_pld_len, want.pld_len);
                    check_field("blk_len", m_blk_len, want.blk_len);
                    results_checked++;
                    status_seen[int'(want.status)]++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_PROTO_SIG) proto_sig_cfg = cfg_data;
                else if (cfg_index == CFG_DATA_SIG) data_sig_cfg = cfg_data;
            end
            if (s_valid && s_ready) begin
                predict_header_byte(s_data_byte, s_last_byte);
                bytes_seen++;
            end
        end
    end

    // Byte driver: new transaction only once the previous one is taken
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_taken) begin
            if (tx_bytes.size() > 0 && !tx_pause && $urandom_range(99) >= tx_idle_pct) begin
                next_item = tx_bytes.pop_front();
                s_valid <= 1'b1;
                s_data_byte <= next_item.data;
                s_last_byte <= next_item.last;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Result receiver, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_req && hold_cnt < HOLD_CYCLES) begin
            m_ready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!hold_req) hold_cnt <= 0;
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    function automatic logic [31:0] rand_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // Finished CRC-32 over hdr_buf[lo .. hi-1]
    function automatic logic [31:0] span_crc(input int lo, input int hi);
        logic [31:0] c;
        c = CRC_PRESET;
        for (int k = lo; k < hi; k++) c = crc_update(c, hdr_buf[k]);
        return ~c;
    endfunction

    // Build a full header in hdr_buf from the current signatures
    task automatic make_header(input logic [7:0] typ, input logic [31:0] psz,
                               input logic [31:0] bsz, input bit bad_s1, input bit bad_c1,
                               input bit bad_s2, input bit bad_c2);
        logic [31:0] c;
        int          hit;
        hdr_buf.delete();
        hit = $urandom_range(SIG_N - 1);
        for (int i = 0; i < SIG_N; i++)
            hdr_buf.push_back(gen_proto[8*i +: 8] ^
                              ((bad_s1 && i == hit) ? 8'($urandom_range(255, 1)) : 8'h00));
        hdr_buf.push_back(typ);
        c = span_crc(0, SIG_N + 1);
        if (bad_c1) c ^= 32'h1 << $urandom_range(31);
        for (int i = 3; i >= 0; i--) hdr_buf.push_back(c[8*i +: 8]);

        hit = $urandom_range(SIG_N - 1);
        for (int i = 0; i < SIG_N; i++)
            hdr_buf.push_back(gen_data[8*i +: 8] ^
                              ((bad_s2 && i == hit) ? 8'($urandom_range(255, 1)) : 8'h00));
        for (int i = 0; i < 4; i++) hdr_buf.push_back(psz[8*i +: 8]);
        for (int i = 0; i < 4; i++) hdr_buf.push_back(bsz[8*i +: 8]);
        c = span_crc(PSEC_N, BSZ_END);
        if (bad_c2) c ^= 32'h1 << $urandom_range(31);
        for (int i = 3; i >= 0; i--) hdr_buf.push_back(c[8*i +: 8]);
    endtask

    // Queue bytes lo..hi-1 of hdr_buf; past its end, random filler
    task automatic queue_span(input int lo, input int hi, input bit mark_last);
        hdr_item_t it;
        for (int k = lo; k < hi; k++) begin
            it.data = (k < hdr_buf.size()) ? hdr_buf[k] : 8'($urandom);
            it.last = mark_last && (k == hi - 1);
            tx_bytes.push_back(it);
        end
    endtask

    // Mostly full-length headers, some of them damaged; others short, long or pure noise
    task automatic queue_random_traffic(input int n_bytes);
        int stop;
        int r;
        stop = tx_bytes.size() + n_bytes;
        while (tx_bytes.size() < stop) begin
            r = $urandom_range(99);
            make_header(8'($urandom), rand_word(), rand_word(), $urandom_range(9) == 0,
                        $urandom_range(9) == 0, $urandom_range(9) == 0,
                        $urandom_range(9) == 0);
            if (r < 8) begin
                hdr_buf.delete();
                queue_span(0, $urandom_range(1, 6), 1'b1);
            end else if (r < 28) begin
                queue_span(0, $urandom_range(1, HDR_N - 1), 1'b1);
            end else if (r < 36) begin
                queue_span(0, HDR_N + $urandom_range(1, 4), 1'b1);
            end else begin
                queue_span(0, HDR_N, 1'b1);
            end
        end
    endtask

    // Quiet point: everything sent and every verdict returned
    task automatic wait_idle();
        while (tx_bytes.size() != 0 || s_valid || header_verdicts.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_PROTO_SIG) gen_proto = val;
        else gen_data = val;
    endtask

    task automatic new_signatures();
        write_reg(CFG_PROTO_SIG, {$urandom, $urandom});
        write_reg(CFG_DATA_SIG, {$urandom, $urandom});
    endtask

    initial begin
        logic [63:0] next_sig;
        logic [63:0] old_sig;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: reset signatures with all-zero fields, then all-ones
        make_header(8'h00, '0, '0, 0, 0, 0, 0);
        queue_span(0, HDR_N, 1'b1);
        wait_idle();
        write_reg(CFG_PROTO_SIG, '1);
        write_reg(CFG_DATA_SIG, '1);
        make_header(8'hFF, '1, '1, 0, 0, 0, 0);
        queue_span(0, HDR_N, 1'b1);
        wait_idle();

        // Directed: length errors and each failed check, plus a priority mix
        new_signatures();
        make_header(8'($urandom), $urandom, $urandom, 0, 0, 0, 0);
        queue_span(0, 1, 1'b1);
        queue_span(0, HDR_N - 1, 1'b1);
        queue_span(0, HDR_N + 3, 1'b1);
        make_header(8'($urandom), $urandom, $urandom, 0, 1, 0, 0);
        queue_span(0, HDR_N, 1'b1);
        make_header(8'($urandom), $urandom, $urandom, 1, 0, 0, 0);
        queue_span(0, HDR_N, 1'b1);
        make_header(8'($urandom), $urandom, $urandom, 0, 0, 0, 1);
        queue_span(0, HDR_N, 1'b1);
        make_header(8'($urandom), $urandom, $urandom, 0, 0, 1, 0);
        queue_span(0, HDR_N, 1'b1);
        make_header(8'($urandom), $urandom, $urandom, 1, 0, 1, 1);
        queue_span(0, HDR_N, 1'b1);
        wait_idle();

        // Directed: second signature rewritten between the two sections
        next_sig = {$urandom, $urandom};
        old_sig = gen_data;
        gen_data = next_sig;
        make_header(8'($urandom), $urandom, $urandom, 0, 0, 0, 0);
        gen_data = old_sig;
        queue_span(0, PSEC_N, 1'b0);
        wait_idle();
        write_reg(CFG_DATA_SIG, next_sig);
        queue_span(PSEC_N, HDR_N, 1'b1);
        wait_idle();

        // Sender idles often, receiver mostly stalled
        tx_idle_pct = 37;
        rx_idle_pct = 86;
        new_signatures();
        queue_random_traffic(100);
        wait_idle();

        // Roles swapped; sender pauses midway until all verdicts are back
        tx_idle_pct = 86;
        rx_idle_pct = 37;
        new_signatures();
        queue_random_traffic(100);
        while (tx_bytes.size() > 50) @(posedge aclk);
        tx_pause = 1'b1;
        while (header_verdicts.size() != 0 || s_valid) @(posedge aclk);
        tx_pause = 1'b0;
        wait_idle();

        // No idling; long receiver hold-off against a burst of short headers
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_PROTO_SIG, '0);
        write_reg(CFG_DATA_SIG, '1);
        hold_req = 1'b1;
        hdr_buf.delete();
        repeat (30) queue_span(0, $urandom_range(1, 3), 1'b1);
        while (hold_cnt != HOLD_CYCLES) @(posedge aclk);
        hold_req = 1'b0;
        queue_random_traffic(100);
        wait_idle();

        $display("Checked %0d verdicts over %0d header bytes: %0d ok, %0d truncated,",
                 results_checked, bytes_seen, status_seen[STATUS_OK],
                 status_seen[STATUS_TRUNCATED]);
        $display("%0d bad CRC, %0d unknown protocol, %0d too long; three idle mixes, stalls.",
                 status_seen[STATUS_BAD_CRC], status_seen[STATUS_UNKNOWN],
                 status_seen[STATUS_TOO_LONG]);
        if (fail_count == 0) begin
            $display("framed_header_validator_top test passed");
        end else begin
            $display("framed_header_validator_top test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(WATCHDOG_NS);
        $display("%0t: timeout", $time);
        $display("framed_header_validator_top test failed");
        $finish;
    end

endmodule
